// ----- rtl/sexp_pkg.sv -----
`timescale 1ns / 1ps
// sexp_pkg: token, error and scanner phase codes, the per-request result bundle
// and byte classification helpers for the s-expression tokenizer. No dependencies.
package sexp_pkg;

   localparam logic [5:0] MAX_DEPTH = 6'd32;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [3:0] RADIX     = 4'd10;

   localparam logic [1:0] ERR_STRAY  = 2'd0;
   localparam logic [1:0] ERR_ESCAPE = 2'd1;
   localparam logic [1:0] ERR_DEEP   = 2'd2;
   localparam logic [1:0] ERR_NONE   = 2'd0;

   typedef enum logic [2:0] {
      TK_LBEGIN = 3'd0,
      TK_LEND   = 3'd1,
      TK_ABYTE  = 3'd2,
      TK_AEND   = 3'd3,
      TK_IEND   = 3'd4,
      TK_SBYTE  = 3'd5,
      TK_SEND   = 3'd6,
      TK_ERROR  = 3'd7
   } token_type;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_LIST    = 3'd1,
      PH_ATOM    = 3'd2,
      PH_STRING  = 3'd3,
      PH_ESCAPE  = 3'd4,
      PH_COMMENT = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   // results of one request: a leading token (list begin or a closing token),
   // a second token, then a run of list ends counting down from unw
   typedef struct packed {
      logic        s0_vld;
      token_type   s0_tok;
      logic [63:0] s0_val;
      logic [5:0]  s0_lvl;
      logic        s1_vld;
      token_type   s1_tok;
      logic [7:0]  s1_chr;
      logic [1:0]  s1_err;
      logic [5:0]  s1_lvl;
      logic [5:0]  unw;
   } bundle_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_TAB) || (c == CH_LF) || (c == CH_SPACE);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_atom(input logic [7:0] c);
      logic r;
      r = is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
      unique case (c)
         8'h5F, 8'h24, 8'h23, 8'h3F, 8'h2E, 8'h40, 8'h2B, 8'h2D, 8'h21, 8'h7E,
         8'h2A, 8'h2F, 8'h25, 8'h3C, 8'h3E, 8'h26, 8'h5E, 8'h7C, 8'h3D: r = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic is_open(input logic [7:0] c);
      return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
   endfunction

   function automatic logic is_close(input logic [7:0] c);
      return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
   endfunction

endpackage

// ----- rtl/sexp_scan.sv -----
`timescale 1ns / 1ps
// sexp_scan: scanner state (phase, depth, digit flag, saturating accumulator)
// and the result bundle of each accepted request. Depends on sexp_pkg.
module sexp_scan import sexp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       kind,
   input  logic [7:0] chr,
   output logic       push,
   output bundle_type bundle
);

   phase_type   phase_ff, phase_in;
   logic [5:0]  depth_ff, depth_in;
   logic        digits_ff, digits_in;
   logic [63:0] accum_ff, accum_in;

   logic        live;
   logic        start;
   phase_type   p;
   logic [5:0]  d0;
   logic        between_en;
   logic [3:0]  digit;
   logic [67:0] prod;
   logic [63:0] acc_next;
   logic [7:0]  esc_chr;
   logic        esc_ok;

   assign live  = accept && (phase_ff != PH_DONE);
   assign start = (phase_ff == PH_START);
   assign p     = start ? PH_LIST : phase_ff;
   assign d0    = start ? 6'd1 : depth_ff;
   assign digit = 4'(chr - CH_ZERO);

   // accum * 10 + digit as shift-add, saturating on carry out of 64 bits
   assign prod     = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1) + {64'd0, digit};
   assign acc_next = (|prod[67:64]) ? {64{1'b1}} : prod[63:0];

   assign between_en = live && !kind &&
                       ((p == PH_LIST) || ((p == PH_ATOM) && !is_atom(chr)));

   always_comb begin
      esc_ok  = 1'b1;
      esc_chr = chr;
      unique case (chr)
         CH_BSLASH:  esc_chr = CH_BSLASH;
         CH_QUOTE:   esc_chr = CH_QUOTE;
         CH_LOWER_N: esc_chr = CH_LF;
         CH_LOWER_R: esc_chr = CH_CR;
         CH_LOWER_T: esc_chr = CH_TAB;
         default:    esc_ok  = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      depth_in  = depth_ff;
      digits_in = digits_ff;
      accum_in  = accum_ff;
      if (live) begin
         phase_in = p;
         depth_in = d0;
         if (kind) begin
            phase_in = PH_DONE;
            depth_in = 6'd0;
         end else begin
            unique case (p)
               PH_ATOM: begin
                  if (is_atom(chr)) begin
                     if (is_digit(chr)) accum_in = acc_next;
                     else digits_in = 1'b0;
                  end else begin
                     phase_in = PH_LIST;
                  end
               end
               PH_STRING: begin
                  if (chr == CH_QUOTE) phase_in = PH_LIST;
                  else if (chr == CH_BSLASH) phase_in = PH_ESCAPE;
               end
               PH_ESCAPE: phase_in = PH_STRING;
               PH_COMMENT: begin
                  if (chr == CH_LF) phase_in = PH_LIST;
               end
               default: ;
            endcase
            if (between_en) begin
               if (is_ws(chr)) begin
                  phase_in = PH_LIST;
               end else if (chr == CH_SEMI) begin
                  phase_in = PH_COMMENT;
               end else if (is_open(chr)) begin
                  if (d0 < MAX_DEPTH) depth_in = 6'(d0 + 6'd1);
               end else if (is_close(chr)) begin
                  depth_in = (d0 != 6'd0) ? 6'(d0 - 6'd1) : 6'd0;
                  if (d0 <= 6'd1) phase_in = PH_DONE;
               end else if (chr == CH_QUOTE) begin
                  phase_in = PH_STRING;
               end else if (is_atom(chr)) begin
                  phase_in  = PH_ATOM;
                  digits_in = is_digit(chr);
                  accum_in  = is_digit(chr) ? {60'd0, digit} : 64'd0;
               end
            end
         end
      end
   end

   // result bundle
   always_comb begin
      bundle = '0;
      if (live) begin
         if (start) begin
            bundle.s0_vld = 1'b1;
            bundle.s0_tok = TK_LBEGIN;
            bundle.s0_lvl = 6'd1;
         end else if ((p == PH_ATOM) && (kind || !is_atom(chr))) begin
            bundle.s0_vld = 1'b1;
            bundle.s0_tok = digits_ff ? TK_IEND : TK_AEND;
            bundle.s0_val = digits_ff ? accum_ff : 64'd0;
            bundle.s0_lvl = d0;
         end else if (kind && ((p == PH_STRING) || (p == PH_ESCAPE))) begin
            bundle.s0_vld = 1'b1;
            bundle.s0_tok = TK_SEND;
            bundle.s0_lvl = d0;
         end
         if (kind) begin
            bundle.unw = d0;
         end else begin
            bundle.s1_lvl = d0;
            unique case (p)
               PH_ATOM: begin
                  if (is_atom(chr)) begin
                     bundle.s1_vld = 1'b1;
                     bundle.s1_tok = TK_ABYTE;
                     bundle.s1_chr = chr;
                  end
               end
               PH_STRING: begin
                  if (chr == CH_QUOTE) begin
                     bundle.s1_vld = 1'b1;
                     bundle.s1_tok = TK_SEND;
                  end else if (chr != CH_BSLASH) begin
                     bundle.s1_vld = 1'b1;
                     bundle.s1_tok = TK_SBYTE;
                     bundle.s1_chr = chr;
                  end
               end
               PH_ESCAPE: begin
                  bundle.s1_vld = 1'b1;
                  bundle.s1_tok = esc_ok ? TK_SBYTE : TK_ERROR;
                  bundle.s1_chr = esc_chr;
                  bundle.s1_err = esc_ok ? ERR_NONE : ERR_ESCAPE;
               end
               default: ;
            endcase
            if (between_en) begin
               if (is_ws(chr) || (chr == CH_SEMI) || (chr == CH_QUOTE)) begin
                  bundle.s1_vld = 1'b0;
               end else if (is_open(chr)) begin
                  bundle.s1_vld = 1'b1;
                  if (d0 >= MAX_DEPTH) begin
                     bundle.s1_tok = TK_ERROR;
                     bundle.s1_chr = chr;
                     bundle.s1_err = ERR_DEEP;
                  end else begin
                     bundle.s1_tok = TK_LBEGIN;
                     bundle.s1_lvl = 6'(d0 + 6'd1);
                  end
               end else if (is_close(chr)) begin
                  bundle.s1_vld = 1'b1;
                  bundle.s1_tok = TK_LEND;
                  bundle.s1_lvl = (d0 != 6'd0) ? 6'(d0 - 6'd1) : 6'd0;
               end else if (is_atom(chr)) begin
                  bundle.s1_vld = 1'b1;
                  bundle.s1_tok = TK_ABYTE;
                  bundle.s1_chr = chr;
               end else begin
                  bundle.s1_vld = 1'b1;
                  bundle.s1_tok = TK_ERROR;
                  bundle.s1_chr = chr;
                  bundle.s1_err = ERR_STRAY;
               end
            end
         end
      end
   end

   assign push = bundle.s0_vld || bundle.s1_vld || (bundle.unw != 6'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         depth_ff  <= 6'd0;
         digits_ff <= 1'b1;
         accum_ff  <= 64'd0;
      end else begin
         phase_ff  <= phase_in;
         depth_ff  <= depth_in;
         digits_ff <= digits_in;
         accum_ff  <= accum_in;
      end
   end

endmodule

// ----- rtl/sexp_fifo.sv -----
`timescale 1ns / 1ps
// sexp_fifo: two-entry queue of result bundles between scanner and emitter.
// Depends on sexp_pkg.
module sexp_fifo import sexp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type wr_data,
   input  logic       pop,
   output logic       not_empty,
   output logic       full,
   output bundle_type rd_data
);

   bundle_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rd_data   = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/sexp_emit.sv -----
`timescale 1ns / 1ps
// sexp_emit: unpacks result bundles into single results, one per cycle while rsp_ready allows,
// into the registered response port. Depends on sexp_pkg.
module sexp_emit import sexp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  bundle_type  q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token,
   output logic [7:0]  rsp_char_out,
   output logic [63:0] rsp_int_value,
   output logic [1:0]  rsp_error_code,
   output logic [5:0]  rsp_level,
   output logic        rsp_last
);

   bundle_type  work_ff, work_in;
   logic        work_vld_ff, work_vld_in;
   logic        valid_ff, valid_in;
   token_type   tok_ff, tok_in;
   logic [7:0]  chr_ff, chr_in;
   logic [63:0] val_ff, val_in;
   logic [1:0]  err_ff, err_in;
   logic [5:0]  lvl_ff, lvl_in;
   logic        last_ff, last_in;

   logic        out_free;
   logic        fire;
   bundle_type  rest;
   logic        more;

   assign out_free = !valid_ff || rsp_ready;
   assign fire     = out_free && work_vld_ff;

   always_comb begin
      rest   = work_ff;
      tok_in = tok_ff;
      chr_in = chr_ff;
      val_in = val_ff;
      err_in = err_ff;
      lvl_in = lvl_ff;
      priority if (work_ff.s0_vld) begin
         rest.s0_vld = 1'b0;
         tok_in = work_ff.s0_tok;
         chr_in = 8'd0;
         val_in = work_ff.s0_val;
         err_in = ERR_NONE;
         lvl_in = work_ff.s0_lvl;
      end else if (work_ff.s1_vld) begin
         rest.s1_vld = 1'b0;
         tok_in = work_ff.s1_tok;
         chr_in = work_ff.s1_chr;
         val_in = 64'd0;
         err_in = work_ff.s1_err;
         lvl_in = work_ff.s1_lvl;
      end else begin
         // unwinding list ends at end of source
         rest.unw = 6'(work_ff.unw - 6'd1);
         tok_in = TK_LEND;
         chr_in = 8'd0;
         val_in = 64'd0;
         err_in = ERR_NONE;
         lvl_in = 6'(work_ff.unw - 6'd1);
      end
      more    = rest.s0_vld || rest.s1_vld || (rest.unw != 6'd0);
      last_in = !more;
   end

   always_comb begin
      work_in     = work_ff;
      work_vld_in = work_vld_ff;
      q_pop       = 1'b0;
      if (fire && more) begin
         work_in = rest;
      end else if (fire || !work_vld_ff) begin
         q_pop       = q_not_empty;
         work_vld_in = q_not_empty;
         work_in     = q_data;
      end
      valid_in = out_free ? work_vld_ff : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_vld_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         work_vld_ff <= work_vld_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (fire) begin
         tok_ff  <= tok_in;
         chr_ff  <= chr_in;
         val_ff  <= val_in;
         err_ff  <= err_in;
         lvl_ff  <= lvl_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_token      = 3'(tok_ff);
   assign rsp_char_out   = chr_ff;
   assign rsp_int_value  = val_ff;
   assign rsp_error_code = err_ff;
   assign rsp_level      = lvl_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- rtl/s_expression_tokenizer.sv -----
`timescale 1ns / 1ps
// s_expression_tokenizer: top level, scanner -> bundle queue -> emitter.
// Depends on sexp_pkg, sexp_scan, sexp_fifo, sexp_emit.
//
// Usage:
//   req channel takes one source byte (req_kind 0) or an end-of-source mark
//   (req_kind 1) per request; rsp channel returns tokens one per transfer,
//   with rsp_last high on the final token caused by a request. Requests that
//   cause no token (whitespace, comments, an opening quote, a backslash)
//   produce nothing.
//   Path: the first token of a request goes through the bundle queue and the
//   emitter's work register into the output register that drives rsp.
//   Throughput: one request per cycle while each causes at most one token
//   and rsp_ready is high; a request causing more tokens holds the response
//   port until all are out (an end mark closing deep nesting gives up to 33).
//   The port emits one token per ready cycle and sets the sustained rate.
//   A two-entry bundle queue decouples the sides: req_ready drops only when
//   it is full, so a stalled receiver backs up into the request side after
//   four token-producing requests: two queued, one waiting in the emitter
//   and one held on the response port.
//   Reset (synchronous, active high) empties the queue and output register and
//   returns the scanner to the start of a program; the first request after
//   reset is preceded by the implicit list begin. After the top-level list
//   closes, every request is accepted and dropped until reset.
module s_expression_tokenizer import sexp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_byte_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token,
   output logic [7:0]  rsp_char_out,
   output logic [63:0] rsp_int_value,
   output logic [1:0]  rsp_error_code,
   output logic [5:0]  rsp_level,
   output logic        rsp_last
);

   logic       accept;
   logic       push;
   bundle_type bundle;
   logic       q_full;
   logic       q_not_empty;
   logic       q_pop;
   bundle_type q_data;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   sexp_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .kind   (req_kind),
      .chr    (req_byte_req),
      .push   (push),
      .bundle (bundle)
   );

   sexp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_data   (bundle),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .rd_data   (q_data)
   );

   sexp_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token      (rsp_token),
      .rsp_char_out   (rsp_char_out),
      .rsp_int_value  (rsp_int_value),
      .rsp_error_code (rsp_error_code),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for s_expression_tokenizer, with a token predictor
// kept in a scoreboard class. Depends on sexp_pkg and the s_expression_tokenizer rtl.
module tb import sexp_pkg::*; ();

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int DIRECTED_COUNT = 25;
   localparam int PHASE_ITEMS    = 100;

   localparam logic [7:0] DIRECTED [DIRECTED_COUNT] = '{
      "(", "0", "9", ")", "[", "z", "7", " ", CH_QUOTE, CH_BSLASH, "n", CH_BSLASH, "q",
      8'hFF, CH_QUOTE, "]", CH_SEMI, "(", CH_LF, 8'h00, "{", 8'h80, "}", CH_CR, CH_TAB
   };

   typedef struct packed {
      token_type   tok;
      logic [7:0]  chr;
      logic [63:0] val;
      logic [1:0]  err;
      logic [5:0]  lvl;
      logic        last;
   } token_rec_type;

   class token_scoreboard;
      phase_type     phase;
      logic [5:0]    depth;
      bit            digits_only;
      logic [63:0]   number;
      token_rec_type pending_tokens[$];
      int            failures;

      function new();
         phase = PH_START;
         depth = '0;
         digits_only = 1'b1;
         number = '0;
         failures = 0;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == CH_TAB || c == CH_LF || c == CH_SPACE;
      endfunction

      function bit is_decimal(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_opener(logic [7:0] c);
         return c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE;
      endfunction

      function bit is_closer(logic [7:0] c);
         return c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE;
      endfunction

      function bit is_atom_char(logic [7:0] c);
         if (is_decimal(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return 1'b1;
         case (c)
            "_", "$", "#", "?", ".", "@", "+", "-", "!", "~",
            "*", "/", "%", "<", ">", "&", "^", "|", "=": return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void add_token(token_type tok, logic [7:0] chr, logic [63:0] val,
                              logic [1:0] err);
         token_rec_type r;
         r.tok = tok;
         r.chr = chr;
         r.val = val;
         r.err = err;
         r.lvl = depth;
         r.last = 1'b0;
         pending_tokens.push_back(r);
      endfunction

      function void finish_atom();
         if (digits_only) add_token(TK_IEND, 8'h00, number, ERR_NONE);
         else add_token(TK_AEND, 8'h00, 64'd0, ERR_NONE);
         phase = PH_LIST;
      endfunction

      function void scan_between(logic [7:0] c);
         if (is_blank(c)) return;
         if (c == CH_SEMI) begin
            phase = PH_COMMENT;
         end else if (is_opener(c)) begin
            if (depth >= MAX_DEPTH) begin
               add_token(TK_ERROR, c, 64'd0, ERR_DEEP);
            end else begin
               depth++;
               add_token(TK_LBEGIN, 8'h00, 64'd0, ERR_NONE);
            end
         end else if (is_closer(c)) begin
            if (depth > 0) depth--;
            add_token(TK_LEND, 8'h00, 64'd0, ERR_NONE);
            if (depth == 0) phase = PH_DONE;
         end else if (c == CH_QUOTE) begin
            phase = PH_STRING;
         end else if (is_atom_char(c)) begin
            phase = PH_ATOM;
            digits_only = is_decimal(c);
            number = digits_only ? 64'(c - CH_ZERO) : 64'd0;
            add_token(TK_ABYTE, c, 64'd0, ERR_NONE);
         end else begin
            add_token(TK_ERROR, c, 64'd0, ERR_STRAY);
         end
      endfunction

      function void scan_atom(logic [7:0] c);
         logic [63:0] digit;
         if (!is_atom_char(c)) begin
            finish_atom();
            scan_between(c);
            return;
         end
         if (is_decimal(c)) begin
            digit = 64'(c - CH_ZERO);
            // saturate instead of wrapping
            if (number > ({64{1'b1}} - digit) / 64'(RADIX)) number = {64{1'b1}};
            else number = number * 64'(RADIX) + digit;
         end else begin
            digits_only = 1'b0;
         end
         add_token(TK_ABYTE, c, 64'd0, ERR_NONE);
      endfunction

      function void scan_escape(logic [7:0] c);
         phase = PH_STRING;
         case (c)
            CH_BSLASH:  add_token(TK_SBYTE, CH_BSLASH, 64'd0, ERR_NONE);
            CH_QUOTE:   add_token(TK_SBYTE, CH_QUOTE, 64'd0, ERR_NONE);
            CH_LOWER_N: add_token(TK_SBYTE, CH_LF, 64'd0, ERR_NONE);
            CH_LOWER_R: add_token(TK_SBYTE, CH_CR, 64'd0, ERR_NONE);
            CH_LOWER_T: add_token(TK_SBYTE, CH_TAB, 64'd0, ERR_NONE);
            default:    add_token(TK_ERROR, c, 64'd0, ERR_ESCAPE);
         endcase
      endfunction

      function void note_request(logic kind, logic [7:0] c);
         int n_before;
         n_before = pending_tokens.size();
         // after the program closes everything is dropped
         if (phase == PH_DONE) return;
         if (phase == PH_START) begin
            depth = 6'd1;
            add_token(TK_LBEGIN, 8'h00, 64'd0, ERR_NONE);
            phase = PH_LIST;
         end
         if (kind == KIND_END) begin
            if (phase == PH_ATOM) finish_atom();
            else if (phase == PH_STRING || phase == PH_ESCAPE)
               add_token(TK_SEND, 8'h00, 64'd0, ERR_NONE);
            while (depth > 0) begin
               depth--;
               add_token(TK_LEND, 8'h00, 64'd0, ERR_NONE);
            end
            phase = PH_DONE;
         end else begin
            case (phase)
               PH_LIST: scan_between(c);
               PH_ATOM: scan_atom(c);
               PH_STRING: begin
                  if (c == CH_QUOTE) begin
                     add_token(TK_SEND, 8'h00, 64'd0, ERR_NONE);
                     phase = PH_LIST;
                  end else if (c == CH_BSLASH) begin
                     phase = PH_ESCAPE;
                  end else begin
                     add_token(TK_SBYTE, c, 64'd0, ERR_NONE);
                  end
               end
               PH_ESCAPE: scan_escape(c);
               default: begin
                  if (c == CH_LF) phase = PH_LIST;
               end
            endcase
         end
         if (pending_tokens.size() > n_before)
            pending_tokens[pending_tokens.size() - 1].last = 1'b1;
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_token(logic [2:0] tok, logic [7:0] chr, logic [63:0] val,
                                logic [1:0] err, logic [5:0] lvl, logic last);
         token_rec_type want;
         if (pending_tokens.size() == 0) begin
            failures++;
            $display("%0t: extra token, expected none, actual %0d/%02h/%0h/%0d/%0d/%b",
                     $time, tok, chr, val, err, lvl, last);
            return;
         end
         want = pending_tokens.pop_front();
         check_field("token", 64'(want.tok), 64'(tok));
         check_field("char_out", 64'(want.chr), 64'(chr));
         check_field("int_value", want.val, val);
         check_field("error_code", 64'(want.err), 64'(err));
         check_field("level", 64'(want.lvl), 64'(lvl));
         check_field("last", 64'(want.last), 64'(last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_BYTE;
   logic [7:0]  req_byte_req = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_token;
   logic [7:0]  rsp_char_out;
   logic [63:0] rsp_int_value;
   logic [1:0]  rsp_error_code;
   logic [5:0]  rsp_level;
   logic        rsp_last;

   token_scoreboard sb = new();
   int    send_idle = 14;
   int    recv_idle = 73;
   int    items_sent = 0;
   int    quiet_cycles = 0;
   string punct = "_$#?.@+-!~*/%<>&^|=";

   s_expression_tokenizer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_byte_req   (req_byte_req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token      (rsp_token),
      .rsp_char_out   (rsp_char_out),
      .rsp_int_value  (rsp_int_value),
      .rsp_error_code (rsp_error_code),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_token(rsp_token, rsp_char_out, rsp_int_value, rsp_error_code, rsp_level,
                        rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called and returns at a falling edge
   task automatic drive_request(logic kind, logic [7:0] b);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_byte_req <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, b);
      items_sent++;
      @(negedge clock);
   endtask

   // keeps the top-level list open until the final sequence
   task automatic send_byte(logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (sb.is_closer(c) && sb.depth <= 1 && (sb.phase == PH_LIST || sb.phase == PH_ATOM))
         c = "x";
      drive_request(KIND_BYTE, c);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending_tokens.size() != 0);
   endtask

   function automatic logic [7:0] pick_opener();
      case ($urandom_range(2))
         0: return CH_LPAREN;
         1: return CH_LBRACK;
         default: return CH_LBRACE;
      endcase
   endfunction

   function automatic logic [7:0] pick_closer();
      case ($urandom_range(2))
         0: return CH_RPAREN;
         1: return CH_RBRACK;
         default: return CH_RBRACE;
      endcase
   endfunction

   function automatic logic [7:0] pick_atom_char();
      case ($urandom_range(3))
         0: return 8'("a" + $urandom_range(25));
         1: return 8'("A" + $urandom_range(25));
         2: return 8'("0" + $urandom_range(9));
         default: return punct[$urandom_range(punct.len() - 1)];
      endcase
   endfunction

   // get back between tokens before a well-formed sequence
   task automatic settle();
      while (sb.phase != PH_LIST) begin
         case (sb.phase)
            PH_ATOM:   send_byte(CH_SPACE);
            PH_STRING: send_byte(CH_QUOTE);
            PH_ESCAPE: send_byte(CH_LOWER_T);
            default:   send_byte(CH_LF);
         endcase
      end
   endtask

   task automatic send_atom();
      int  len;
      bit  numeric;
      numeric = $urandom_range(1);
      // long digit runs push the value into saturation
      len = ($urandom_range(7) == 0) ? $urandom_range(19, 24) : $urandom_range(1, 5);
      repeat (len) send_byte(numeric ? 8'("0" + $urandom_range(9)) : pick_atom_char());
      case ($urandom_range(5))
         0: send_byte(CH_SPACE);
         1: send_byte(CH_LF);
         2: send_byte(CH_TAB);
         3: send_byte(pick_closer());
         4: send_byte(pick_opener());
         default: send_byte(8'($urandom_range(255)));
      endcase
   endtask

   task automatic send_string();
      logic [7:0] b;
      send_byte(CH_QUOTE);
      repeat ($urandom_range(6)) begin
         if ($urandom_range(3) == 0) begin
            send_byte(CH_BSLASH);
            case ($urandom_range(5))
               0: b = CH_BSLASH;
               1: b = CH_QUOTE;
               2: b = CH_LOWER_N;
               3: b = CH_LOWER_R;
               4: b = CH_LOWER_T;
               default: b = 8'($urandom_range(255));
            endcase
            send_byte(b);
         end else begin
            b = 8'($urandom_range(255));
            if (b == CH_QUOTE || b == CH_BSLASH) b = "s";
            send_byte(b);
         end
      end
      settle();
   endtask

   task automatic send_comment();
      logic [7:0] b;
      send_byte(CH_SEMI);
      repeat ($urandom_range(5)) begin
         b = 8'($urandom_range(255));
         send_byte(b == CH_LF ? 8'h20 : b);
      end
      send_byte(CH_LF);
   endtask

   task automatic send_deep_nest();
      while (sb.depth < MAX_DEPTH) send_byte(pick_opener());
      repeat ($urandom_range(1, 2)) send_byte(pick_opener());
      repeat ($urandom_range(1, 31)) send_byte(pick_closer());
   endtask

   task automatic send_random_sequence();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         send_byte(8'($urandom_range(255)));
      end else begin
         settle();
         if (pick < 45) send_atom();
         else if (pick < 60) send_string();
         else if (pick < 68) send_comment();
         else if (pick < 82) send_byte(pick_opener());
         else if (pick < 97) send_byte(pick_closer());
         else send_deep_nest();
      end
   endtask

   task automatic send_program_end();
      settle();
      if ($urandom_range(1)) begin
         while (sb.depth < MAX_DEPTH) send_byte(pick_opener());
      end else begin
         repeat ($urandom_range(3)) send_byte(pick_opener());
      end
      case ($urandom_range(5))
         0: repeat ($urandom_range(1, 3)) send_byte(8'("0" + $urandom_range(9)));
         1: begin
            send_byte(CH_QUOTE);
            send_byte("a");
         end
         2: begin
            send_byte(CH_QUOTE);
            send_byte(CH_BSLASH);
         end
         3: begin
            send_byte(CH_SEMI);
            send_byte("x");
         end
         4: ;
         default: begin
            // close the top-level list instead of ending the source
            while (sb.phase != PH_DONE) drive_request(KIND_BYTE, pick_closer());
         end
      endcase
      drive_request(KIND_END, 8'($urandom_range(255)));
      repeat (3) drive_request(1'($urandom_range(1)), 8'($urandom_range(255)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) drive_request(KIND_BYTE, DIRECTED[i]);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle = 14;
               recv_idle = 73;
            end
            1: begin
               send_idle = 73;
               recv_idle = 14;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         while (items_sent < DIRECTED_COUNT + PHASE_ITEMS * (p + 1)) send_random_sequence();
         wait_drained();
      end

      send_program_end();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending_tokens.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
